>>> rtl/core/texel_unpack_to_rgba8_assert.svh
// assertion macros for the texel unpacker
// used by texel_unpack_to_rgba8.sv; no other dependencies
`ifndef TEXEL_UNPACK_TO_RGBA8_ASSERT_SVH
`define TEXEL_UNPACK_TO_RGBA8_ASSERT_SVH
`ifndef SYNTHESIS
`define TU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("texel_unpack_to_rgba8: assertion failed");
`define TU_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("texel_unpack_to_rgba8: forbidden condition seen");
`else
`define TU_ASSERT(label, clk, rst, prop)
`define TU_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/core/tu_pkg.sv
// shared constants, codes and structs for the texel unpacker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package tu_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // configuration register widths
  localparam int DIM_W     = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // stride is at least the width, at most what the register holds
  localparam int STR_W = (COL_W > DIM_W) ? COL_W : DIM_W;
  localparam int POS_W = STR_W + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 3'd4;

  // component order codes
  localparam logic [1:0] ORDER_RGB  = 2'd0;
  localparam logic [1:0] ORDER_RGBA = 2'd1;
  localparam logic [1:0] ORDER_BGR  = 2'd2;
  localparam logic [1:0] ORDER_BGRA = 2'd3;

  // packing codes
  localparam logic [1:0] PACK_BYTES = 2'd0;
  localparam logic [1:0] PACK_MSB   = 2'd1;
  localparam logic [1:0] PACK_LSB   = 2'd2;
  localparam logic [1:0] PACK_RSVD  = 2'd3;

  // bytes per source texel
  localparam logic [2:0] BPT_PACKED = 3'd2;
  localparam logic [2:0] BPT_RGB    = 3'd3;
  localparam logic [2:0] BPT_RGBA   = 3'd4;

  typedef struct packed {
    logic             skip;
    logic             has_alpha;
    logic             swapped;
    logic [1:0]       packing;
    logic [2:0]       bpt;
    logic [COL_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [POS_W-1:0] texel_bytes;
    logic [POS_W-1:0] row_bytes;
  } geom_t;

  typedef struct packed {
    logic        emit;
    logic        end_of_row;
    logic        end_of_image;
    logic [31:0] all_bytes;
  } texel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

endpackage

>>> rtl/core/texel_unpack_to_rgba8.sv
// top level of the texel unpacker: input register, result register, handshake
// depends on tu_pkg, tu_cfg_regs, tu_position, tu_convert and the assert header
`timescale 1ns / 1ps
`include "texel_unpack_to_rgba8_assert.svh"

// Usage
// Raw upload bytes come in on data_byte with byte_valid/byte_stall; a transfer
// happens on a rising edge with byte_valid high and byte_stall low. Converted
// texels go out on red/green/blue/alpha with end_of_row and end_of_image under
// texel_valid/texel_stall, with the same transfer rule.
// Each byte first lands in an input register; the position logic and the
// converter work on it there and load any finished texel into the result
// register, from which it is offered. One byte is taken every cycle, set by
// the single input register feeding the single result register, unless a
// finished texel waits on a stalled result; bytes that finish no texel
// (partial texels, row padding, ignored formats) never wait on the output.
// When the receiver stalls, the result register holds its texel and one more
// byte may sit in the input register; a byte that would finish a texel waits
// there and byte_stall goes high until the result register frees up.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once and
// belong between images, while no byte or texel is in flight.
// Reset (rst, synchronous) restores the register defaults (RGBA bytes, 1x1
// image, stride equal to width), clears all counters and drops both valids.

module texel_unpack_to_rgba8 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [tu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tu_pkg::CFG_W-1:0]     cfg_data,
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  logic [7:0]                   data_byte,
  output logic                         texel_valid,
  input  logic                         texel_stall,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic [7:0]                   alpha,
  output logic                         end_of_row,
  output logic                         end_of_image
);

  tu_pkg::geom_t  geom;
  tu_pkg::texel_t info;
  tu_pkg::rgba_t  color;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free;
  logic       advance;
  logic       load_result;
  logic       byte_take;

  tu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  tu_position u_position (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (held_byte),
    .geom      (geom),
    .info      (info)
  );

  tu_convert u_convert (
    .geom      (geom),
    .all_bytes (info.all_bytes),
    .color     (color)
  );

  always_comb begin
    out_free    = !texel_valid || !texel_stall;
    // a byte that finishes no texel never waits on the output side
    advance     = held_valid && (!info.emit || out_free);
    load_result = advance && info.emit;
    byte_stall  = held_valid && !advance;
    byte_take   = byte_valid && !byte_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      held_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_valid <= 1'b0;
    end else if (load_result) begin
      texel_valid <= 1'b1;
    end else if (!texel_stall) begin
      texel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      red          <= color.red;
      green        <= color.green;
      blue         <= color.blue;
      alpha        <= color.alpha;
      end_of_row   <= info.end_of_row;
      end_of_image <= info.end_of_image;
    end
  end

  // a byte held back is not dropped
  `TU_ASSERT(a_held_kept, clk, rst, byte_stall |=> held_valid)
  // a finished texel always shows up on the output
  `TU_ASSERT(a_result_loaded, clk, rst, load_result |=> texel_valid)
  // the last texel of the image also closes its row
  `TU_ASSERT_NEVER(a_eoi_without_eor, clk, rst, texel_valid && end_of_image && !end_of_row)
  // a result is never loaded over one that is still stalled
  `TU_ASSERT_NEVER(a_no_overwrite, clk, rst, load_result && texel_valid && texel_stall)

endmodule

>>> rtl/core/tu_cfg_regs.sv
// configuration registers and the row geometry derived from them
// depends on tu_pkg
`timescale 1ns / 1ps

module tu_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [tu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tu_pkg::CFG_W-1:0]     cfg_data,
  output tu_pkg::geom_t                geom
);

  logic [1:0]               component_order;
  logic [1:0]               texel_packing;
  logic [tu_pkg::DIM_W-1:0] image_width;
  logic [tu_pkg::DIM_W-1:0] image_height;
  logic [tu_pkg::DIM_W-1:0] source_row_length;

  logic [tu_pkg::COL_W-1:0] width;
  logic [tu_pkg::HGT_W-1:0] height;
  logic [tu_pkg::STR_W-1:0] stride;
  logic [tu_pkg::POS_W-1:0] stride_wide;
  logic [tu_pkg::POS_W-1:0] width_wide;
  logic [tu_pkg::POS_W-1:0] stride_bytes;
  logic [tu_pkg::POS_W-1:0] texel_bytes;
  logic [tu_pkg::POS_W-1:0] padded_sum;
  logic                     has_alpha;
  logic [2:0]               bpt;

  always_ff @(posedge clk) begin
    if (rst) begin
      component_order   <= tu_pkg::ORDER_RGBA;
      texel_packing     <= tu_pkg::PACK_BYTES;
      image_width       <= tu_pkg::DIM_W'(1);
      image_height      <= tu_pkg::DIM_W'(1);
      source_row_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tu_pkg::REG_ORDER:   component_order   <= cfg_data[1:0];
        tu_pkg::REG_PACKING: texel_packing     <= cfg_data[1:0];
        tu_pkg::REG_WIDTH:   image_width       <= cfg_data[tu_pkg::DIM_W-1:0];
        tu_pkg::REG_HEIGHT:  image_height      <= cfg_data[tu_pkg::DIM_W-1:0];
        tu_pkg::REG_STRIDE:  source_row_length <= cfg_data[tu_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    has_alpha = (component_order == tu_pkg::ORDER_RGBA) ||
                (component_order == tu_pkg::ORDER_BGRA);

    // zero counts as one, large values saturate
    if (image_width == '0)
      width = tu_pkg::COL_W'(1);
    else if (32'(image_width) > 32'(tu_pkg::MAX_WIDTH))
      width = tu_pkg::COL_W'(tu_pkg::MAX_WIDTH);
    else
      width = tu_pkg::COL_W'(image_width);

    if (image_height == '0)
      height = tu_pkg::HGT_W'(1);
    else if (32'(image_height) > 32'(tu_pkg::MAX_HEIGHT))
      height = tu_pkg::HGT_W'(tu_pkg::MAX_HEIGHT);
    else
      height = tu_pkg::HGT_W'(image_height);

    // a short or missing stride counts as the width
    if (source_row_length == '0 || 32'(source_row_length) < 32'(width))
      stride = tu_pkg::STR_W'(width);
    else
      stride = tu_pkg::STR_W'(source_row_length);

    if (texel_packing != tu_pkg::PACK_BYTES)
      bpt = tu_pkg::BPT_PACKED;
    else if (has_alpha)
      bpt = tu_pkg::BPT_RGBA;
    else
      bpt = tu_pkg::BPT_RGB;

    stride_wide = tu_pkg::POS_W'(stride);
    width_wide  = tu_pkg::POS_W'(width);
    case (bpt)
      tu_pkg::BPT_PACKED: begin
        stride_bytes = stride_wide << 1;
        texel_bytes  = width_wide << 1;
      end
      tu_pkg::BPT_RGB: begin
        stride_bytes = (stride_wide << 1) + stride_wide;
        texel_bytes  = (width_wide << 1) + width_wide;
      end
      default: begin
        stride_bytes = stride_wide << 2;
        texel_bytes  = width_wide << 2;
      end
    endcase
    // rows are padded to a multiple of four bytes
    padded_sum = stride_bytes + tu_pkg::POS_W'(3);

    geom.skip        = (texel_packing == tu_pkg::PACK_RSVD) ||
                       (texel_packing != tu_pkg::PACK_BYTES && !has_alpha);
    geom.has_alpha   = has_alpha;
    geom.swapped     = component_order[1];
    geom.packing     = texel_packing;
    geom.bpt         = bpt;
    geom.width       = width;
    geom.height      = height;
    geom.texel_bytes = texel_bytes;
    geom.row_bytes   = {padded_sum[tu_pkg::POS_W-1:2], 2'b00};
  end

endmodule

>>> rtl/core/tu_position.sv
// row and texel position tracking, byte gathering and texel completion
// depends on tu_pkg
`timescale 1ns / 1ps

module tu_position (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  tu_pkg::geom_t geom,
  output tu_pkg::texel_t info
);

  logic [tu_pkg::POS_W-1:0] row_byte_position, row_byte_position_next;
  logic [23:0]              gathered_bytes, gathered_bytes_next;
  logic [1:0]               byte_in_texel, byte_in_texel_next;
  logic [tu_pkg::COL_W-1:0] column_index, column_index_next;
  logic [tu_pkg::ROW_W-1:0] row_index, row_index_next;

  logic                     in_row;
  logic                     texel_done;
  logic                     row_done;
  logic [tu_pkg::POS_W:0]   pos_inc;
  logic [tu_pkg::COL_W:0]   col_inc;
  logic [tu_pkg::HGT_W:0]   row_inc;
  logic [31:0]              new_byte;

  always_comb begin
    in_row     = (row_byte_position < geom.texel_bytes) && (column_index < geom.width);
    texel_done = ({1'b0, byte_in_texel} + 3'd1) >= geom.bpt;
    pos_inc    = {1'b0, row_byte_position} + (tu_pkg::POS_W + 1)'(1);
    col_inc    = {1'b0, column_index} + (tu_pkg::COL_W + 1)'(1);
    row_inc    = (tu_pkg::HGT_W + 1)'(row_index) + (tu_pkg::HGT_W + 1)'(1);
    row_done   = pos_inc >= {1'b0, geom.row_bytes};

    // last byte lands above the ones already gathered
    case (geom.bpt)
      tu_pkg::BPT_PACKED: new_byte = {16'h0, data_byte, 8'h0};
      tu_pkg::BPT_RGB:    new_byte = {8'h0, data_byte, 16'h0};
      default:            new_byte = {data_byte, 24'h0};
    endcase

    info.emit         = !geom.skip && in_row && texel_done;
    info.all_bytes    = {8'h0, gathered_bytes} | new_byte;
    info.end_of_row   = col_inc == {1'b0, geom.width};
    info.end_of_image = info.end_of_row && (row_inc == {1'b0, geom.height});
  end

  always_comb begin
    row_byte_position_next = row_byte_position;
    gathered_bytes_next    = gathered_bytes;
    byte_in_texel_next     = byte_in_texel;
    column_index_next      = column_index;
    row_index_next         = row_index;

    if (step && !geom.skip) begin
      if (in_row) begin
        if (texel_done) begin
          column_index_next   = col_inc[tu_pkg::COL_W-1:0];
          byte_in_texel_next  = '0;
          gathered_bytes_next = '0;
        end else begin
          case (byte_in_texel)
            2'd0:    gathered_bytes_next[7:0]   = gathered_bytes[7:0] | data_byte;
            2'd1:    gathered_bytes_next[15:8]  = gathered_bytes[15:8] | data_byte;
            2'd2:    gathered_bytes_next[23:16] = gathered_bytes[23:16] | data_byte;
            default: ;
          endcase
          byte_in_texel_next = byte_in_texel + 2'd1;
        end
      end

      if (row_done) begin
        row_byte_position_next = '0;
        column_index_next      = '0;
        byte_in_texel_next     = '0;
        gathered_bytes_next    = '0;
        // wrap to the first row so images can follow back to back
        if (row_inc >= {1'b0, geom.height})
          row_index_next = '0;
        else
          row_index_next = row_inc[tu_pkg::ROW_W-1:0];
      end else begin
        row_byte_position_next = pos_inc[tu_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_byte_position <= '0;
      gathered_bytes    <= '0;
      byte_in_texel     <= '0;
      column_index      <= '0;
      row_index         <= '0;
    end else begin
      row_byte_position <= row_byte_position_next;
      gathered_bytes    <= gathered_bytes_next;
      byte_in_texel     <= byte_in_texel_next;
      column_index      <= column_index_next;
      row_index         <= row_index_next;
    end
  end

endmodule

>>> rtl/core/tu_convert.sv
// component extraction: byte orders and 4444 nibble expansion to rgba8
// depends on tu_pkg
`timescale 1ns / 1ps

module tu_convert (
  input  tu_pkg::geom_t geom,
  input  logic [31:0]   all_bytes,
  output tu_pkg::rgba_t color
);

  logic [7:0] c0, c1, c2, c3;

  // n * 17 is the nibble repeated
  function automatic logic [7:0] expand(input logic [3:0] n);
    expand = {n, n};
  endfunction

  always_comb begin
    case (geom.packing)
      tu_pkg::PACK_MSB: begin
        c0 = expand(all_bytes[15:12]);
        c1 = expand(all_bytes[11:8]);
        c2 = expand(all_bytes[7:4]);
        c3 = expand(all_bytes[3:0]);
      end
      tu_pkg::PACK_LSB: begin
        c0 = expand(all_bytes[3:0]);
        c1 = expand(all_bytes[7:4]);
        c2 = expand(all_bytes[11:8]);
        c3 = expand(all_bytes[15:12]);
      end
      default: begin
        c0 = all_bytes[7:0];
        c1 = all_bytes[15:8];
        c2 = all_bytes[23:16];
        c3 = geom.has_alpha ? all_bytes[31:24] : 8'hFF;
      end
    endcase

    color.red   = geom.swapped ? c2 : c0;
    color.green = c1;
    color.blue  = geom.swapped ? c0 : c2;
    color.alpha = c3;
  end

endmodule
